// ===== sv/pce_pkg.sv =====
// Shared constants and helper functions for the polynomial combine and evaluate unit.
package pce_pkg;
    localparam int MAX_DEGREE_DEF = 15;
    localparam logic [1:0] OP_SET_DEGREE = 2'd0;
    localparam logic [1:0] OP_LOAD_COEF  = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    // saturate a 64-bit value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh000000007fffffff) r = SAT_MAX;
        else if (v < -64'sh0000000080000000) r = SAT_MIN;
        else r = v[31:0];
        return r;
    endfunction

    // round a Q32.32 product to Q16.16, half toward plus infinity
    function automatic logic signed [63:0] round_q16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t >>> 16;
    endfunction
endpackage

// ===== sv/pce_mac.sv =====
// Registered 32x32 signed multiplier with Q16.16 rounding.
module pce_mac (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);
    logic signed [63:0] r_prod;

    // register the exact product, round on the output side
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end
    assign o_prod = pce_pkg::round_q16(r_prod);
endmodule

// ===== sv/polynomial_combine_evaluate_unit.sv =====
// Top level: polynomial store, f = -(p+q)*(r-s) sequencer and result stream.
//  channel | dir | fields
//  s_axis  | in  | tuser=operation, tdata={x,coef,power,which}
//  m_axis  | out | tuser=kind, tdata={value,power}, tlast=last
// Set-degree and load items are handled in idle. A compute item is sequenced
// through the one shared registered multiplier and the coefficient memory,
// which has one registered read port; output stalls hold the sequencer.
// Synchronous active-low reset clears degrees and control.
// The output register holds a result until taken; the sequencer waits.
module polynomial_combine_evaluate_unit #(
    parameter int MAX_DEGREE = pce_pkg::MAX_DEGREE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // which[1:0], power[5:2], coef[37:6], x[69:38]
    input  logic [1:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // power[4:0], value[36:5]
    output logic        m_axis_tuser,  // kind
    output logic        m_axis_tlast   // last
);
    localparam int NC = MAX_DEGREE + 1;
    localparam int NP = 2 * MAX_DEGREE + 1;
    localparam int DW = $clog2(NC);
    localparam int PW = $clog2(NP + 1);
    localparam int CAW = $clog2(4 * NC);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001, S_SUM1 = 10'b0000000010,
        S_SUM2 = 10'b0000000100, S_TRIM = 10'b0000001000,
        S_CLR  = 10'b0000010000, S_MUL  = 10'b0000100000,
        S_MACC = 10'b0001000000, S_EVAL = 10'b0010000000,
        S_EACC = 10'b0100000000, S_EMIT = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [3:0]  r_deg [4];
    logic signed [31:0] r_cmem [4*NC];
    logic signed [31:0] r_sa [NC];
    logic signed [31:0] r_sb [NC];
    logic signed [63:0] r_acc [NP];
    logic signed [31:0] r_prod [NP];
    logic signed [31:0] r_rd;
    logic        r_pass;
    logic [DW-1:0] r_i, r_j, r_d1, r_d2;
    logic [1:0]  r_ph;
    logic [PW-1:0] r_k, r_df;
    logic signed [31:0] r_x, r_t;
    logic signed [63:0] r_s;
    logic        r_ov;
    logic [4:0]  r_opw;
    logic signed [31:0] r_oval;
    logic        r_okind;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_mp;

    wire [1:0]  in_op  = s_axis_tuser;
    wire [1:0]  in_wh  = s_axis_tdata[1:0];
    wire [3:0]  in_pw  = s_axis_tdata[5:2];
    wire fire = s_axis_tvalid && s_axis_tready;

    function automatic logic [DW-1:0] cdeg(input logic [3:0] d);
        return (32'(d) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(d);
    endfunction

    // degrees of the two operands of the current sum pass
    wire [DW-1:0] da = r_pass ? cdeg(r_deg[2]) : cdeg(r_deg[0]);
    wire [DW-1:0] db = r_pass ? cdeg(r_deg[3]) : cdeg(r_deg[1]);
    wire [DW-1:0] dk = (da > db) ? da : db;

    pce_mac u_mac (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_prod(w_mp));
    assign w_ma = (r_state == S_EVAL || r_state == S_EACC) ?
                  (r_ph == 2'd0 ? r_prod[r_k] : r_t) : r_sa[r_i];
    assign w_mb = (r_state == S_EVAL || r_state == S_EACC) ?
                  (r_ph == 2'd0 ? r_t : r_x) : r_sb[r_j];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'd0, r_oval, r_opw};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_okind;

    // coefficient memory: write on loads, registered read for sums
    always_ff @(posedge i_clk) begin
        if (fire && in_op == pce_pkg::OP_LOAD_COEF && 32'(in_pw) <= MAX_DEGREE)
            r_cmem[CAW'(32'(in_wh) * NC + 32'(in_pw))] <= s_axis_tdata[37:6];
        r_rd <= r_cmem[CAW'((r_pass ? 32'd2 : 32'd0) * NC +
                  ((r_ph != 2'd0) ? 32'(NC) : 32'd0) + 32'(r_i))];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        logic signed [31:0] v;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
            for (int n = 0; n < 4; n++) r_deg[n] <= '0;
        end else begin
            if (r_ov && m_axis_tready && r_state != S_EMIT) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (fire && in_op == pce_pkg::OP_SET_DEGREE)
                        r_deg[in_wh] <= (32'(in_pw) > MAX_DEGREE) ?
                                        4'(MAX_DEGREE) : in_pw;
                    if (fire && in_op == pce_pkg::OP_COMPUTE) begin
                        r_x <= s_axis_tdata[69:38];
                        r_pass <= 1'b0; r_i <= '0; r_ph <= 2'd0;
                        r_state <= S_SUM1;
                        for (int n = 0; n < NC; n++) begin
                            r_sa[n] <= '0; r_sb[n] <= '0;
                        end
                    end
                end
                // phase 0 reads a, 1 captures a and reads b, 2 holds the b read
                S_SUM1: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else if (r_ph == 2'd1) begin
                        v = (r_i <= da) ? r_rd : 32'sd0;
                        if (r_pass) r_sb[r_i] <= v; else r_sa[r_i] <= v;
                        r_ph <= 2'd2;
                    end else begin
                        r_ph <= 2'd0;
                        r_state <= S_SUM2;
                    end
                end
                S_SUM2: begin
                    logic signed [31:0] a, b;
                    a = r_pass ? r_sb[r_i] : r_sa[r_i];
                    b = (r_i <= db) ? r_rd : 32'sd0;
                    if (r_pass) b = pce_pkg::sat32(-64'(b));
                    v = pce_pkg::sat32(64'(a) + 64'(b));
                    if (r_pass) r_sb[r_i] <= v; else r_sa[r_i] <= v;
                    if (r_i == dk) begin
                        r_state <= S_TRIM;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SUM1;
                    end
                end
                // trim trailing zeros one step per cycle, then negate p+q (first pass) or go to the product (second)
                S_TRIM: begin
                    v = r_pass ? r_sb[r_i] : r_sa[r_i];
                    if (r_i != '0 && v == 32'sd0) r_i <= r_i - 1'b1;
                    else if (!r_pass) begin
                        r_d1 <= r_i;
                        for (int n = 0; n < NC; n++)
                            r_sa[n] <= pce_pkg::sat32(-64'(r_sa[n]));
                        r_pass <= 1'b1; r_i <= '0; r_state <= S_SUM1;
                    end else begin
                        r_d2 <= r_i;
                        r_df <= PW'(r_d1) + PW'(r_i);
                        r_k <= '0; r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    for (int n = 0; n < NP; n++) r_acc[n] <= '0;
                    r_i <= '0; r_j <= '0; r_state <= S_MUL;
                end
                S_MUL: r_state <= S_MACC;
                S_MACC: begin
                    r_acc[PW'(r_i) + PW'(r_j)] <= r_acc[PW'(r_i) + PW'(r_j)] + w_mp;
                    if (r_j != r_d2) begin
                        r_j <= r_j + 1'b1; r_state <= S_MUL;
                    end else if (r_i != r_d1) begin
                        r_j <= '0; r_i <= r_i + 1'b1; r_state <= S_MUL;
                    end else begin
                        for (int n = 0; n < NP; n++)
                            r_prod[n] <= pce_pkg::sat32(r_acc[n] +
                                ((n == 32'(r_i) + 32'(r_j)) ? w_mp : 64'sd0));
                        r_t <= pce_pkg::ONE_Q16; r_s <= '0; r_k <= '0;
                        r_ph <= 2'd0; r_state <= S_EVAL;
                    end
                end
                // ph0 term f[k]*t, ph1 t*x
                S_EVAL: r_state <= S_EACC;
                S_EACC: begin
                    if (r_ph == 2'd0) begin
                        r_s <= r_s + w_mp; r_ph <= 2'd1; r_state <= S_EVAL;
                    end else begin
                        r_t <= pce_pkg::sat32(w_mp); r_ph <= 2'd0;
                        if (r_k == r_df) begin
                            r_k <= '0; r_state <= S_EMIT;
                        end else begin
                            r_k <= r_k + 1'b1; r_state <= S_EVAL;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov <= 1'b1;
                        if (r_ph == 2'd0) begin
                            r_okind <= 1'b0; r_opw <= 5'(r_k);
                            r_oval <= r_prod[r_k];
                            if (r_k == r_df) r_ph <= 2'd1;
                            else r_k <= r_k + 1'b1;
                        end else begin
                            r_okind <= 1'b1; r_opw <= '0;
                            r_oval <= pce_pkg::sat32(r_s);
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] == 5'd0)
        else $error("value item with nonzero power");
`endif
endmodule
